>>> hdl/bbdq_pkg.sv
// Shared types, sizes and codes for the byte-budget drop-oldest event deque.
package bbdq_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int TAG_W   = 32;
  localparam int SIZE_W  = 16;
  localparam int BYTES_W = 21;
  localparam int MAX_W   = 20;
  localparam int CMD_W   = 2;
  localparam int KIND_W  = 3;
  localparam int OCNT_W  = 5;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 80;

  localparam logic [MAX_W-1:0] MAX_BYTES_RESET = MAX_W'(65536);

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP        = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POPPED   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EVICTED  = 3'd4;

  // One stored event.
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // Per-cell move controls; at most one is set in a cycle.
  typedef struct packed {
    logic shift_front;  // take the neighbor behind (toward the back)
    logic shift_back;   // take the neighbor in front (cell 0 takes the new event)
    logic load;         // write the new event in place
  } cell_ctl_t;

endpackage

>>> hdl/bbdq_cell.sv
// One slot of the deque row: holds an event and moves it toward either neighbor.
module bbdq_cell (
  input  logic               clk,
  input  bbdq_pkg::cell_ctl_t ctl,
  input  bbdq_pkg::entry_t   from_back,
  input  bbdq_pkg::entry_t   from_front,
  input  bbdq_pkg::entry_t   new_entry,
  output bbdq_pkg::entry_t   q
);
  import bbdq_pkg::*;

  always_ff @(posedge clk) begin
    priority if (ctl.shift_front) begin
      q <= from_back;
    end else if (ctl.shift_back) begin
      q <= from_front;
    end else if (ctl.load) begin
      q <= new_entry;
    end else begin
      q <= q;
    end
  end

endmodule

>>> hdl/byte_budget_drop_oldest_deque_core.sv
// Top level of the byte-budget drop-oldest event deque.
// The deque holds up to DEPTH events (tag and byte size) in a row of cells, the
// oldest in cell 0. A back push first evicts the oldest events, one result item
// each, while the store is full or the new size would overflow the byte budget,
// then always stores the event; a front push is rejected unless it fits; a pop
// returns the front event or reports empty. An input item is taken in only while
// the core is idle, and work on it goes on until its last result item is in the
// result register; each evicted event adds one more result item. The single
// shared result register takes one result item per cycle unless the downstream
// side holds tready low, which stalls the work. An input item with the unused
// command code is taken in and produces no result.
// The budget register may be written only while no item is in flight.
module byte_budget_drop_oldest_deque_core (
  input  logic                               clk,
  input  logic                               rst,
  // Input items.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [bbdq_pkg::IN_DATA_W-1:0]     s_tdata,   // event_tag[31:0], event_size[47:32]
  input  logic [bbdq_pkg::CMD_W-1:0]         s_tuser,   // command[1:0]
  // Result items.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bbdq_pkg::OUT_DATA_W-1:0]    m_tdata,   // out_tag[31:0], out_size[47:32],
                                                        // item_count[52:48], bytes_used[73:53],
                                                        // is_empty[74], zero[79:75]
  output logic [bbdq_pkg::KIND_W-1:0]        m_tuser,   // kind[2:0]
  output logic                               m_tlast,   // last
  // Budget register write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bbdq_pkg::MAX_W-1:0]         cfg_data
);
  import bbdq_pkg::*;

  typedef enum logic {ST_IDLE, ST_WORK} state_t;

  state_t                state;
  logic [CMD_W-1:0]      cmd_q;
  entry_t                new_entry;
  logic [CNT_W-1:0]      count;
  logic [BYTES_W-1:0]    total;
  logic [MAX_W-1:0]      max_bytes;

  entry_t                cell_q   [DEPTH];
  cell_ctl_t             cell_ctl [DEPTH];

  // Decisions for the current work cycle.
  logic                  out_free;
  logic                  fire;
  logic                  over_budget;
  logic                  full;
  logic                  do_shift_front;
  logic                  do_shift_back;
  logic                  do_load;
  logic [KIND_W-1:0]     res_kind;
  entry_t                res_entry;
  logic                  res_last;
  logic [CNT_W-1:0]      count_next;
  logic [BYTES_W-1:0]    total_next;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // The result register is free when empty or when its item leaves this cycle.
  assign out_free = !m_tvalid || m_tready;
  assign fire     = (state == ST_WORK) && out_free;

  // The budget test is done one bit wider so a sum past 2^21 never wraps.
  assign over_budget = ({1'b0, total} + (BYTES_W + 1)'(new_entry.size))
                       > (BYTES_W + 1)'(max_bytes);
  assign full        = (count == CNT_W'(DEPTH));

  always_comb begin
    do_shift_front = 1'b0;
    do_shift_back  = 1'b0;
    do_load        = 1'b0;
    res_kind       = KIND_ACCEPTED;
    res_entry      = '0;
    res_last       = 1'b1;
    count_next     = count;
    total_next     = total;
    unique case (cmd_q)
      CMD_PUSH_BACK: begin
        if ((count != '0) && (full || over_budget)) begin
          // Drop the oldest event and stay on this item.
          do_shift_front = 1'b1;
          res_kind       = KIND_EVICTED;
          res_entry      = cell_q[0];
          res_last       = 1'b0;
          count_next     = count - CNT_W'(1);
          total_next     = total - BYTES_W'(cell_q[0].size);
        end else begin
          do_load    = 1'b1;
          count_next = count + CNT_W'(1);
          total_next = total + BYTES_W'(new_entry.size);
        end
      end
      CMD_PUSH_FRONT: begin
        if (full || over_budget) begin
          res_kind = KIND_REJECTED;
        end else begin
          do_shift_back = 1'b1;
          count_next    = count + CNT_W'(1);
          total_next    = total + BYTES_W'(new_entry.size);
        end
      end
      CMD_POP: begin
        if (count == '0) begin
          res_kind = KIND_EMPTY;
        end else begin
          do_shift_front = 1'b1;
          res_kind       = KIND_POPPED;
          res_entry      = cell_q[0];
          count_next     = count - CNT_W'(1);
          total_next     = total - BYTES_W'(cell_q[0].size);
        end
      end
      default: begin
        // Unused code never reaches the work state.
      end
    endcase
  end

  // Row of cells: cell 0 is the front, the back ends at cell count-1.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t from_back;
    entry_t from_front;

    assign cell_ctl[i].shift_front = fire && do_shift_front;
    assign cell_ctl[i].shift_back  = fire && do_shift_back;
    assign cell_ctl[i].load        = fire && do_load && (count == CNT_W'(i));

    if (i == DEPTH - 1) begin : g_tail
      assign from_back = '0;
    end else begin : g_mid
      assign from_back = cell_q[i+1];
    end

    if (i == 0) begin : g_head
      assign from_front = new_entry;
    end else begin : g_rest
      assign from_front = cell_q[i-1];
    end

    bbdq_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .from_back  (from_back),
      .from_front (from_front),
      .new_entry  (new_entry),
      .q          (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      count     <= '0;
      total     <= '0;
      max_bytes <= MAX_BYTES_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_bytes <= cfg_data;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_q          <= s_tuser;
            new_entry.tag  <= s_tdata[TAG_W-1:0];
            new_entry.size <= s_tdata[TAG_W +: SIZE_W];
            // The unused command code is dropped here without a result.
            if (s_tuser == CMD_PUSH_BACK || s_tuser == CMD_PUSH_FRONT ||
                s_tuser == CMD_POP) begin
              state <= ST_WORK;
            end
          end
        end
        ST_WORK: begin
          if (fire && res_last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (fire) begin
        count    <= count_next;
        total    <= total_next;
        m_tvalid <= 1'b1;
        m_tuser  <= res_kind;
        m_tlast  <= res_last;
        m_tdata  <= {5'b0, (count_next == '0), total_next, OCNT_W'(count_next),
                     res_entry.size, res_entry.tag};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // The row never holds more events than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // The empty flag of a result agrees with its entry count.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[74] == (m_tdata[52:48] == '0)))
    else $error("empty flag disagrees with entry count");

  // An eviction is always followed by more results for the same item.
  a_evict_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_EVICTED) |-> !m_tlast)
    else $error("eviction marked as final result");

  // A valid command taken in leads to work on it in the next cycle.
  a_cmd_starts_work: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready &&
     (s_tuser == CMD_PUSH_BACK || s_tuser == CMD_PUSH_FRONT || s_tuser == CMD_POP))
    |=> (state == ST_WORK))
    else $error("accepted item did not start work");

  // A result is produced only by a work cycle, never out of the idle state.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_WORK))
    else $error("result produced outside work state");

endmodule

>>> test/byte_budget_drop_oldest_deque_core_test.sv
// Self-checking testbench for the byte-budget drop-oldest event deque core.
`timescale 1ns / 1ps

module byte_budget_drop_oldest_deque_core_test;
  import bbdq_pkg::*;

  // The fourth command code is not assigned; the core must swallow it silently.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned BYTES_MASK = (1 << BYTES_W) - 1;
  localparam int unsigned BUDGET_TOP = (1 << MAX_W) - 1;
  localparam int WATCHDOG_LIMIT = 4000;

  // One expected result item, unpacked into its fields.
  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [TAG_W-1:0]   tag;
    logic [SIZE_W-1:0]  size;
    logic [OCNT_W-1:0]  count;
    logic [BYTES_W-1:0] bytes;
    logic               empty;
    logic               last;
  } deque_result_t;

  // Shadow copy of the deque: tracks contents, fill and budget, and keeps the
  // results each accepted item should produce, oldest first.
  class deque_scoreboard;
    logic [TAG_W-1:0]  tags  [DEPTH];
    logic [SIZE_W-1:0] sizes [DEPTH];
    int unsigned head, count, bytes, budget;
    deque_result_t expected[$];
    int unsigned items_seen, results_seen, evictions, rejections, fails;

    function new();
      head   = 0;
      count  = 0;
      bytes  = 0;
      budget = 32'(MAX_BYTES_RESET);
    endfunction

    function void add_result(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag,
                             logic [SIZE_W-1:0] size);
      deque_result_t r;
      r.kind  = kind;
      r.tag   = tag;
      r.size  = size;
      r.count = count[OCNT_W-1:0];
      r.bytes = bytes[BYTES_W-1:0];
      r.empty = (count == 0);
      r.last  = 1'b0;
      expected = {expected, r};
    endfunction

    // Remove the oldest entry and report it as popped or evicted.
    function void take_oldest(logic [KIND_W-1:0] kind);
      logic [TAG_W-1:0]  t;
      logic [SIZE_W-1:0] s;
      t = tags[head];
      s = sizes[head];
      head  = (head + 1) % DEPTH;
      count = count - 1;
      bytes = (bytes - s) & BYTES_MASK;
      add_result(kind, t, s);
    endfunction

    function void note_input(logic [CMD_W-1:0] cmd, logic [TAG_W-1:0] tag,
                             logic [SIZE_W-1:0] size);
      int unsigned slot;
      items_seen++;
      case (cmd)
        CMD_PUSH_BACK: begin
          // Drop the oldest until the new event fits or nothing is left.
          while (count > 0 && (count >= DEPTH || bytes + size > budget)) begin
            take_oldest(KIND_EVICTED);
            evictions++;
          end
          slot = (head + count) % DEPTH;
          tags[slot]  = tag;
          sizes[slot] = size;
          count = count + 1;
          bytes = (bytes + size) & BYTES_MASK;
          add_result(KIND_ACCEPTED, '0, '0);
        end
        CMD_PUSH_FRONT: begin
          if (count >= DEPTH || bytes + size > budget) begin
            add_result(KIND_REJECTED, '0, '0);
            rejections++;
          end else begin
            slot = (head + DEPTH - 1) % DEPTH;
            tags[slot]  = tag;
            sizes[slot] = size;
            head  = slot;
            count = count + 1;
            bytes = (bytes + size) & BYTES_MASK;
            add_result(KIND_ACCEPTED, '0, '0);
          end
        end
        CMD_POP: begin
          if (count == 0) add_result(KIND_EMPTY, '0, '0);
          else take_oldest(KIND_POPPED);
        end
        default: return;
      endcase
      expected[expected.size() - 1].last = 1'b1;
    endfunction

    function void compare(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic [KIND_W-1:0] kind,
                               logic last);
      deque_result_t want;
      if (expected.size() == 0) begin
        $error("result item with no expectation waiting: kind %0d", kind);
        fails++;
        return;
      end
      want = expected[0];
      expected.delete(0);
      results_seen++;
      compare("kind", want.kind, kind);
      compare("out_tag", want.tag, data[31:0]);
      compare("out_size", want.size, data[47:32]);
      compare("item_count", want.count, data[52:48]);
      compare("bytes_used", want.bytes, data[73:53]);
      compare("is_empty", want.empty, data[74]);
      compare("last", want.last, last);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // event_tag[31:0], event_size[47:32]
  logic [CMD_W-1:0]      s_tuser = '0;   // command[1:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // out_tag, out_size, item_count, bytes_used, is_empty
  logic [KIND_W-1:0]     m_tuser;        // kind[2:0]
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [MAX_W-1:0]      cfg_data = '0;

  deque_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned budgets_used = 1;
  int idle_cycles = 0;

  byte_budget_drop_oldest_deque_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random; the stall rate changes with the run phase.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // All handshakes are observed here at the rising edge. Accepted inputs feed the
  // shadow model, accepted results are checked against it, and budget writes
  // update its copy of the register.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata[31:0], s_tdata[47:32]);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
      if (cfg_valid && cfg_ready) sb.budget = 32'(cfg_data);
    end
  end

  // Watchdog: a long stretch with no handshake on any channel means the core hung.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d result items outstanding", sb.expected.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offers one input item, with random idle cycles in front of it, and returns at
  // the falling edge after it was accepted. Called at a falling edge.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [TAG_W-1:0] tag,
                           logic [SIZE_W-1:0] size);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {size, tag};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds the sender back until every predicted result item has been seen.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.expected.size() != 0) @(negedge clk);
  endtask

  // Budget writes only happen with the core idle. An unused command leaves no
  // result behind, so the task also waits out an item still being taken in.
  task automatic write_budget(logic [MAX_W-1:0] value);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    budgets_used++;
  endtask

  // Random traffic. Most sizes are scaled to the current budget so the deque
  // fills up, evicts and rejects often; the rest span the whole size field.
  task automatic run_random(int n);
    int unsigned pick, cap;
    logic [CMD_W-1:0]  cmd;
    logic [SIZE_W-1:0] size;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(19);
      if (pick < 9)       cmd = CMD_PUSH_BACK;
      else if (pick < 14) cmd = CMD_PUSH_FRONT;
      else if (pick < 19) cmd = CMD_POP;
      else                cmd = CMD_UNUSED;
      cap = sb.budget / 8;
      if (cap > 65535) cap = 65535;
      pick = $urandom_range(9);
      if (pick < 6)      size = SIZE_W'($urandom_range(cap, 0));
      else if (pick < 9) size = SIZE_W'($urandom_range(65535, 0));
      else               size = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      send_item(cmd, $urandom, size);
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, reset budget of 65536 bytes. The largest event fits on its
    // own, a front push one byte over the budget is rejected, one filling the
    // budget exactly goes in, and the unused command must produce nothing.
    send_idle_pct = 13;
    recv_idle_pct = 72;
    send_item(CMD_POP, 32'h0000_0000, 16'h0000);
    send_item(CMD_PUSH_BACK, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(CMD_PUSH_FRONT, 32'h1234_5678, 16'h0002);
    send_item(CMD_PUSH_FRONT, 32'h0000_0000, 16'h0001);
    send_item(CMD_UNUSED, 32'hA5A5_5A5A, 16'h5A5A);
    send_item(CMD_POP, 32'h0000_0000, 16'h0000);

    // Zero budget: a back push evicts everything and is then stored anyway,
    // leaving the byte total above the budget, so even an empty front push fails.
    write_budget('0);
    send_item(CMD_PUSH_BACK, 32'h0BAD_F00D, 16'h0005);
    send_item(CMD_PUSH_FRONT, 32'h0000_0001, 16'h0000);
    send_item(CMD_POP, 32'h0000_0000, 16'h0000);

    // Largest budget: bytes never limit, so the store fills up. The next back
    // push must evict the oldest on count alone and a front push is rejected.
    write_budget(BUDGET_TOP[MAX_W-1:0]);
    for (int i = 0; i <= DEPTH; i++)
      send_item(CMD_PUSH_BACK, $urandom, (i % 2) ? 16'($urandom) : 16'h0000);
    send_item(CMD_PUSH_FRONT, $urandom, 16'h0000);

    // Random phases: sender mostly busy and receiver mostly stalled, then the
    // reverse, then both at full speed. The first phase also stops the sender
    // halfway until the core has delivered everything.
    write_budget(MAX_W'($urandom_range(200000, 40000)));
    run_random(18);
    wait_drained();
    run_random(18);

    send_idle_pct = 72;
    recv_idle_pct = 13;
    write_budget(MAX_W'($urandom_range(30000, 1)));
    run_random(36);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_budget(MAX_BYTES_RESET);
    run_random(32);

    wait_drained();
    repeat (10) @(negedge clk);

    $display("Covered %0d input items and %0d result items over %0d budget settings.",
             sb.items_seen, sb.results_seen, budgets_used);
    $display("Saw %0d evictions and %0d rejected front pushes; %0d mismatches.",
             sb.evictions, sb.rejections, sb.fails);
    if (sb.fails == 0 && sb.expected.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
